// File: rtl/nlpe_pkg.sv
// Shared types and constants for the nearest landmark pixel encoder.
`default_nettype none
package nlpe_pkg;
  typedef enum logic [1:0] {
    CMD_LOAD_LM   = 2'd0,
    CMD_LOAD_COEF = 2'd1,
    CMD_ENCODE    = 2'd2,
    CMD_PROJECT   = 2'd3
  } cmd_e;

  localparam int NumCoeffs = 12;
  localparam logic signed [31:0] HalfQ16 = 32'sh0000_8000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ENC_RD,
    ST_ENC_WR,
    ST_PRJ_RD,
    ST_PRJ_LM,
    ST_ROW1,
    ST_ROW2,
    ST_ROW3,
    ST_ROW4,
    ST_OUT
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_in;     // capture input item
    logic lm_write;    // write landmark entry
    logic coef_write;  // write coefficient
    logic scan_clear;  // reset scan counter and best
    logic scan_step;   // evaluate one landmark
    logic enc_rd;      // read best landmark
    logic enc_wr;      // store offsets to slot
    logic prj_rd;      // read slot
    logic prj_lm;      // read anchor landmark
    logic [1:0] row_sel;
    logic row_go;      // compute one affine row
    logic out_load;    // load output register
    logic is_encode;
  } ctrl_t;

  typedef struct packed {
    logic scan_done;
    logic slot_ok;
    logic lm_ok;
    logic coef_ok;
    logic [1:0] cmd;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fff_ffff;
    if (v < -66'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

// File: rtl/nlpe_if.sv
// Valid/ready channel interfaces for input and result items.
`default_nettype none
interface nlpe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [8:0]  index;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] label_weight;
  modport source (output valid, command, index, coord_x, coord_y, label_weight,
                  input ready);
  modport sink (input valid, command, index, coord_x, coord_y, label_weight,
                output ready);
endinterface

interface nlpe_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  anchor_index;
  logic signed [31:0] result_x;
  logic signed [31:0] result_y;
  logic        found;
  modport source (output valid, anchor_index, result_x, result_y, found, input ready);
  modport sink (input valid, anchor_index, result_x, result_y, found, output ready);
endinterface
`default_nettype wire

// File: rtl/nlpe_ctrl.sv
// Controller state machine sequencing load, encode and project items.
`default_nettype none
module nlpe_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire nlpe_pkg::stat_t stat_i,
  output nlpe_pkg::ctrl_t      ctrl_o
);
  import nlpe_pkg::*;

  state_e state_q, state_d;
  logic   ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign in_ready_o  = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    ov_d    = ov_q && !out_ready_i;
    ctrl_o  = '0;
    ctrl_o.is_encode = (stat_i.cmd == CMD_ENCODE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load_in = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // the state after capture dispatches on command
        case (stat_i.cmd)
          CMD_LOAD_LM: begin
            ctrl_o.lm_write = stat_i.lm_ok;
            state_d = ST_IDLE;
          end
          CMD_LOAD_COEF: begin
            ctrl_o.coef_write = stat_i.coef_ok;
            state_d = ST_IDLE;
          end
          CMD_ENCODE: begin
            ctrl_o.scan_clear = 1'b1;
            state_d = stat_i.slot_ok ? ST_ENC_RD : ST_IDLE;
          end
          default: begin
            ctrl_o.prj_rd = 1'b1;
            state_d = stat_i.slot_ok ? ST_PRJ_RD : ST_IDLE;
          end
        endcase
      end
      ST_ENC_RD: begin
        ctrl_o.scan_step = 1'b1;
        if (stat_i.scan_done) begin
          ctrl_o.scan_step = 1'b0;
          ctrl_o.enc_rd = 1'b1;
          state_d = ST_ENC_WR;
        end
      end
      ST_ENC_WR: begin
        ctrl_o.enc_wr = 1'b1;
        state_d = ST_OUT;
      end
      ST_PRJ_RD: begin
        ctrl_o.prj_lm = 1'b1;
        state_d = ST_PRJ_LM;
      end
      ST_PRJ_LM: begin
        ctrl_o.row_go = 1'b1;
        ctrl_o.row_sel = 2'd0;
        state_d = ST_ROW1;
      end
      ST_ROW1: begin
        ctrl_o.row_go = 1'b1;
        ctrl_o.row_sel = 2'd1;
        state_d = ST_ROW2;
      end
      ST_ROW2: begin
        ctrl_o.row_go = 1'b1;
        ctrl_o.row_sel = 2'd2;
        state_d = ST_ROW3;
      end
      ST_ROW3: begin
        ctrl_o.row_go = 1'b1;
        ctrl_o.row_sel = 2'd3;
        state_d = ST_ROW4;
      end
      ST_ROW4: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // wait for the output register to drain
        if (!ov_q || out_ready_i) begin
          ctrl_o.out_load = 1'b1;
          ov_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == ST_IDLE)) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.out_load |=> out_valid_o) else $error("result not shown");
`endif
endmodule
`default_nettype wire

// File: rtl/nlpe_dp.sv
// Datapath: landmark, coefficient and slot stores, distance scan, affine unit.
`default_nettype none
module nlpe_dp #(
  parameter int MaxLandmarks = 128,
  parameter int MaxPixels    = 512
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire nlpe_pkg::ctrl_t ctrl_i,
  output nlpe_pkg::stat_t      stat_o,
  input  wire logic [1:0]      command_i,
  input  wire logic [8:0]      index_i,
  input  wire logic signed [31:0] coord_x_i,
  input  wire logic signed [31:0] coord_y_i,
  input  wire logic signed [31:0] label_weight_i,
  output logic [6:0]           anchor_index_o,
  output logic signed [31:0]   result_x_o,
  output logic signed [31:0]   result_y_o,
  output logic                 found_o
);
  import nlpe_pkg::*;

  localparam int LW = (MaxLandmarks > 1) ? $clog2(MaxLandmarks) : 1;
  localparam int PW = (MaxPixels > 1) ? $clog2(MaxPixels) : 1;

  // captured item
  logic [1:0]  cmd_q;
  logic [8:0]  idx_q;
  logic signed [31:0] cx_q, cy_q, lw_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      cmd_q <= command_i;
      idx_q <= index_i;
      cx_q  <= coord_x_i;
      cy_q  <= coord_y_i;
      lw_q  <= label_weight_i;
    end
  end

  assign stat_o.cmd     = cmd_q;
  assign stat_o.lm_ok   = {23'd0, idx_q} < MaxLandmarks;
  assign stat_o.slot_ok = {23'd0, idx_q} < MaxPixels;
  assign stat_o.coef_ok = {23'd0, idx_q} < NumCoeffs;

  // landmark memory: one read port, reset value via valid bits
  logic signed [31:0] lm_x_mem [MaxLandmarks];
  logic signed [31:0] lm_y_mem [MaxLandmarks];
  logic [MaxLandmarks-1:0] lm_wr_q, lm_vld_q; // written / label valid
  logic signed [31:0] coef_q [NumCoeffs];

  logic [LW-1:0] lm_waddr;
  assign lm_waddr = idx_q[LW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lm_wr_q  <= '0;
      lm_vld_q <= '0;
      for (int i = 0; i < NumCoeffs; i++) coef_q[i] <= '0;
    end else begin
      if (ctrl_i.lm_write) begin
        lm_wr_q[lm_waddr]  <= 1'b1;
        lm_vld_q[lm_waddr] <= lw_q > HalfQ16;
      end
      if (ctrl_i.coef_write) coef_q[idx_q[3:0]] <= cx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.lm_write) begin
      lm_x_mem[lm_waddr] <= cx_q;
      lm_y_mem[lm_waddr] <= cy_q;
    end
  end

  // scan: address counter, registered read, distance pipeline
  logic [LW:0]   cnt_q;       // read address counter
  logic [LW:0]   p1_q, p2_q;  // index following the read data
  logic          p1v_q, p2v_q;
  logic [LW-1:0] rd_addr;
  logic signed [31:0] rx_q, ry_q;
  logic          rvld_q;
  logic [63:0]   sqa_q, sqb_q;
  logic [LW-1:0] best_q;
  logic          found_q;
  logic [64:0]   bestd_q;
  logic [LW-1:0] anchor_q;
  logic [LW-1:0] anchor_d;
  logic          rw_q;

  always_comb begin
    rd_addr = cnt_q[LW-1:0];
    if (ctrl_i.enc_rd) rd_addr = best_q;
    else if (ctrl_i.prj_lm) rd_addr = anchor_d;
  end

  always_ff @(posedge clk_i) begin
    rx_q <= lm_x_mem[rd_addr];
    ry_q <= lm_y_mem[rd_addr];
    rw_q <= lm_wr_q[rd_addr];
    rvld_q <= lm_vld_q[rd_addr];
  end

  logic signed [32:0] dx, dy;
  logic [32:0] mx, my;
  logic signed [31:0] lx, ly;
  assign lx = rw_q ? rx_q : '0;
  assign ly = rw_q ? ry_q : '0;
  assign dx = 33'(cx_q) - 33'(lx);
  assign dy = 33'(cy_q) - 33'(ly);
  assign mx = dx[32] ? 33'(-dx) : dx;
  assign my = dy[32] ? 33'(-dy) : dy;

  logic p1ok_q;
  logic [64:0] dsum;
  assign dsum = {1'b0, sqa_q} + {1'b0, sqb_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; p1v_q <= 1'b0; p2v_q <= 1'b0; found_q <= 1'b0;
      best_q <= '0; p1ok_q <= 1'b0;
      p1_q <= '0; p2_q <= '0; bestd_q <= '0;
    end else if (ctrl_i.scan_clear) begin
      cnt_q <= '0; p1v_q <= 1'b0; p2v_q <= 1'b0; found_q <= 1'b0;
      best_q <= '0; p1ok_q <= 1'b0;
    end else if (ctrl_i.scan_step) begin
      // advance address; p1 follows the registered read data and p2 the registered squares
      if (cnt_q < (LW+1)'(MaxLandmarks)) cnt_q <= cnt_q + 1'b1;
      p1v_q  <= cnt_q < (LW+1)'(MaxLandmarks);
      p1_q   <= cnt_q;
      p2v_q  <= p1v_q && rvld_q;
      p2_q   <= p1_q;
      if (p2v_q && (!found_q || dsum < bestd_q)) begin
        found_q <= 1'b1;
        best_q  <= p2_q[LW-1:0];
        bestd_q <= dsum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sqa_q <= 64'(mx) * 64'(mx);
    sqb_q <= 64'(my) * 64'(my);
  end

  assign stat_o.scan_done = (cnt_q == (LW+1)'(MaxLandmarks)) && !p1v_q && !p2v_q;

  // slot memory, undefined until written
  logic [6:0]  slot_a_mem [MaxPixels];
  logic signed [31:0] slot_x_mem [MaxPixels];
  logic signed [31:0] slot_y_mem [MaxPixels];
  logic [6:0]  sa_q;
  logic signed [31:0] sx_q, sy_q;
  logic signed [31:0] offx, offy;
  logic [PW-1:0] saddr;
  assign saddr = idx_q[PW-1:0];
  assign offx = sat32(66'(cx_q) - 66'(lx));
  assign offy = sat32(66'(cy_q) - 66'(ly));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.enc_wr) begin
      slot_a_mem[saddr] <= 7'(best_q);
      slot_x_mem[saddr] <= offx;
      slot_y_mem[saddr] <= offy;
    end
    sa_q <= slot_a_mem[saddr];
    sx_q <= slot_x_mem[saddr];
    sy_q <= slot_y_mem[saddr];
  end

  assign anchor_d = ({25'd0, sa_q} < MaxLandmarks) ? sa_q[LW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.prj_lm) anchor_q <= anchor_d;
  end

  // affine unit: one row per cycle
  logic signed [31:0] ax_q, ay_q, rowx_q, rowy_q;
  logic signed [31:0] ra, rb, rc, vx, vy;
  logic signed [63:0] pa, pb;
  logic signed [65:0] rsum;
  logic signed [31:0] rrow;
  logic [1:0] rs_q; logic rg_q;
  logic [3:0] cb;
  assign cb = 4'({2'd0, ctrl_i.row_sel} * 4'd3);
  always_ff @(posedge clk_i) begin
    ra <= coef_q[cb]; rb <= coef_q[cb + 4'd1]; rc <= coef_q[cb + 4'd2];
    rs_q <= ctrl_i.row_sel;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rg_q <= 1'b0;
    else rg_q <= ctrl_i.row_go;
  end
  assign vx = rs_q[1] ? ax_q : sx_q;
  assign vy = rs_q[1] ? ay_q : sy_q;
  assign pa = ra * vx;
  assign pb = rb * vy;
  assign rsum = 66'(pa) + 66'(pb) + {{18{rc[31]}}, rc, 16'd0} + 66'sd32768;
  assign rrow = sat32(rsum >>> 16);

  logic signed [31:0] lmx_q, lmy_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.row_go && ctrl_i.row_sel == 2'd0) begin
      lmx_q <= lx; lmy_q <= ly;
    end
    if (rg_q) begin
      case (rs_q)
        2'd0: ax_q <= rrow;
        2'd1: begin
          // add anchor landmark once both first-matrix rows are done
          ax_q <= sat32(66'(ax_q) + 66'(lmx_q));
          ay_q <= sat32(66'(rrow) + 66'(lmy_q));
        end
        2'd2: rowx_q <= rrow;
        default: rowy_q <= rrow;
      endcase
    end
  end

  logic [6:0] oa_q; logic signed [31:0] ox_q, oy_q; logic of_q;
  logic signed [31:0] eox_q, eoy_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.enc_wr) begin
      eox_q <= offx; eoy_q <= offy;
    end
    if (ctrl_i.out_load) begin
      oa_q  <= ctrl_i.is_encode ? 7'(best_q) : 7'(anchor_q);
      ox_q  <= ctrl_i.is_encode ? eox_q : rowx_q;
      oy_q  <= ctrl_i.is_encode ? eoy_q : rowy_q;
      of_q  <= ctrl_i.is_encode && found_q;
    end
  end
  assign anchor_index_o = oa_q;
  assign result_x_o = ox_q;
  assign result_y_o = oy_q;
  assign found_o = of_q;

`ifndef SYNTHESIS
  a_best_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> ({1'b0, best_q} < (LW+1)'(MaxLandmarks))) else $error("best out of range");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (LW+1)'(MaxLandmarks)) else $error("scan counter overrun");
  a_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.scan_step && ctrl_i.enc_wr)) else $error("scan during store");
`endif
endmodule
`default_nettype wire

// File: rtl/nearest_landmark_pixel_encoder.sv
// Top level: nearest landmark pixel encoder.
`default_nettype none
// In-range load items are written in the dispatch state after capture. An encode
// item scans every landmark entry one per cycle through the landmark memory read
// port, then stores the offsets to its slot. A project item runs four affine
// rows through one shared multiply-add unit. One item is worked on at a time;
// the result register lets the next item enter while a result waits, and a
// held result stalls the following result item.
module nearest_landmark_pixel_encoder #(
  parameter int MAX_LANDMARKS = 128,
  parameter int MAX_PIXELS    = 512
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  nlpe_in_if.sink    in_if,
  nlpe_out_if.source out_if
);
  import nlpe_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  nlpe_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  nlpe_dp #(.MaxLandmarks(MAX_LANDMARKS), .MaxPixels(MAX_PIXELS)) u_dp (
    .clk_i, .rst_ni,
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .command_i     (in_if.command),
    .index_i       (in_if.index),
    .coord_x_i     (in_if.coord_x),
    .coord_y_i     (in_if.coord_y),
    .label_weight_i(in_if.label_weight),
    .anchor_index_o(out_if.anchor_index),
    .result_x_o    (out_if.result_x),
    .result_y_o    (out_if.result_y),
    .found_o       (out_if.found)
  );
endmodule
`default_nettype wire

// File: verif/nlpe_checker.sv
// Scoreboard for the nearest landmark pixel encoder: predicts every result and compares.
`default_nettype none
module nlpe_checker
  import nlpe_pkg::*;
#(
  parameter int MAX_LANDMARKS = 128,
  parameter int MAX_PIXELS    = 512
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  nlpe_in_if        in_mon,
  nlpe_out_if       out_mon,
  output int        errors_o,
  output int        pending_o,
  output int        encodes_o,
  output int        projects_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [6:0]         anchor;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic               found;
  } pixel_result_t;

  logic signed [31:0] lm_x [MAX_LANDMARKS];
  logic signed [31:0] lm_y [MAX_LANDMARKS];
  logic               lm_ok [MAX_LANDMARKS];
  logic [6:0]         slot_anchor [MAX_PIXELS];
  logic signed [31:0] slot_dx [MAX_PIXELS];
  logic signed [31:0] slot_dy [MAX_PIXELS];
  logic signed [31:0] coeff [NumCoeffs];
  pixel_result_t      expected_q[$];

  function automatic logic signed [31:0] clamp32(input logic signed [79:0] v);
    if (v > 80'sd2147483647) return 32'sh7fff_ffff;
    if (v < -80'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Exact a*x + b*y + c, rounded half up to Q16.16.
  function automatic logic signed [31:0] affine_row(input int base,
                                                     input logic signed [31:0] x,
                                                     input logic signed [31:0] y);
    logic signed [79:0] a, b, c, xx, yy, acc;
    a = coeff[base];
    b = coeff[base+1];
    c = coeff[base+2];
    xx = x;
    yy = y;
    acc = a * xx + b * yy + (c <<< 16) + 80'sd32768;
    return clamp32(acc >>> 16);
  endfunction

  function automatic pixel_result_t encode_pixel(input int slot,
                                                 input logic signed [31:0] px,
                                                 input logic signed [31:0] py);
    pixel_result_t r;
    logic signed [67:0] ex, ey, d, best_d;
    logic signed [79:0] wx, wy;
    int best;
    logic hit;
    best = 0;
    hit = 1'b0;
    best_d = '0;
    for (int j = 0; j < MAX_LANDMARKS; j++) begin
      if (lm_ok[j]) begin
        ex = px;
        ex = ex - lm_x[j];
        ey = py;
        ey = ey - lm_y[j];
        d = ex * ex + ey * ey;
        if (!hit || d < best_d) begin
          hit = 1'b1;
          best = j;
          best_d = d;
        end
      end
    end
    wx = px;
    wy = py;
    slot_anchor[slot] = best[6:0];
    slot_dx[slot] = clamp32(wx - lm_x[best]);
    slot_dy[slot] = clamp32(wy - lm_y[best]);
    r.anchor = best[6:0];
    r.rx = slot_dx[slot];
    r.ry = slot_dy[slot];
    r.found = hit;
    return r;
  endfunction

  function automatic pixel_result_t project_pixel(input int slot);
    pixel_result_t r;
    logic signed [31:0] ax, ay;
    logic signed [79:0] sx, sy;
    int a;
    a = slot_anchor[slot];
    ax = affine_row(0, slot_dx[slot], slot_dy[slot]);
    ay = affine_row(3, slot_dx[slot], slot_dy[slot]);
    sx = ax;
    sy = ay;
    sx = clamp32(sx + lm_x[a]);
    sy = clamp32(sy + lm_y[a]);
    r.anchor = a[6:0];
    r.rx = affine_row(6, sx[31:0], sy[31:0]);
    r.ry = affine_row(9, sx[31:0], sy[31:0]);
    r.found = 1'b0;
    return r;
  endfunction

  task automatic report(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    pending_o = 0;
    encodes_o = 0;
    projects_o = 0;
    for (int j = 0; j < MAX_LANDMARKS; j++) begin
      lm_x[j] = '0;
      lm_y[j] = '0;
      lm_ok[j] = 1'b0;
    end
    for (int k = 0; k < NumCoeffs; k++) coeff[k] = '0;
  end

  always @(posedge clk_i) begin
    pixel_result_t got, want;
    if (rst_ni && out_mon.valid && out_mon.ready) begin
      got.anchor = out_mon.anchor_index;
      got.rx = out_mon.result_x;
      got.ry = out_mon.result_y;
      got.found = out_mon.found;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result anchor=%0d x=%h y=%h", got.anchor, got.rx,
                         got.ry));
      end else begin
        want = expected_q.pop_front();
        if (got.anchor !== want.anchor)
          report($sformatf("anchor %0d, expected %0d", got.anchor, want.anchor));
        if (got.rx !== want.rx) report($sformatf("x %h, expected %h", got.rx, want.rx));
        if (got.ry !== want.ry) report($sformatf("y %h, expected %h", got.ry, want.ry));
        if (got.found !== want.found)
          report($sformatf("found %b, expected %b", got.found, want.found));
      end
    end
    if (rst_ni && in_mon.valid && in_mon.ready) begin
      case (cmd_e'(in_mon.command))
        CMD_LOAD_LM: begin
          if (in_mon.index < MAX_LANDMARKS) begin
            lm_x[in_mon.index] = in_mon.coord_x;
            lm_y[in_mon.index] = in_mon.coord_y;
            lm_ok[in_mon.index] = in_mon.label_weight > HalfQ16;
          end
        end
        CMD_LOAD_COEF: begin
          if (in_mon.index < NumCoeffs) coeff[in_mon.index] = in_mon.coord_x;
        end
        CMD_ENCODE: begin
          if (in_mon.index < MAX_PIXELS) begin
            expected_q.push_back(encode_pixel(in_mon.index, in_mon.coord_x, in_mon.coord_y));
            encodes_o++;
          end
        end
        default: begin
          if (in_mon.index < MAX_PIXELS) begin
            expected_q.push_back(project_pixel(in_mon.index));
            projects_o++;
          end
        end
      endcase
    end
    pending_o = expected_q.size();
  end
endmodule
`default_nettype wire

// File: verif/nearest_landmark_pixel_encoder_tb.sv
// Testbench top: drives stimulus into the encoder and gives the verdict.
`default_nettype none
module nearest_landmark_pixel_encoder_tb;
  import nlpe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumLm     = 128;
  localparam int NumSlots  = 512;
  localparam int RandItems = 1800;
  localparam int HoldCycles = 1500;
  localparam longint CycleLimit = 2_000_000;

  logic clk_i;
  logic rst_ni;
  logic calm;
  logic hold_go;
  logic slot_written [NumSlots];
  longint cycles;
  int errors, pending, encodes, projects;

  nlpe_in_if  in_if ();
  nlpe_out_if out_if ();

  nearest_landmark_pixel_encoder u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if.sink),
    .out_if(out_if.source)
  );

  nlpe_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .errors_o  (errors),
    .pending_o (pending),
    .encodes_o (encodes),
    .projects_o(projects)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off, none in the final stretch.
  initial begin
    int burst;
    out_if.ready <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (hold_go) begin
        out_if.ready <= 1'b0;
        for (int c = 0; c < HoldCycles; c++) @(posedge clk_i);
        hold_go <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 15);
        out_if.ready <= 1'b0;
        repeat (burst) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic push_item(input cmd_e cmd, input logic [8:0] idx,
                           input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] lw);
    in_if.valid <= 1'b1;
    in_if.command <= cmd;
    in_if.index <= idx;
    in_if.coord_x <= x;
    in_if.coord_y <= y;
    in_if.label_weight <= lw;
    do @(posedge clk_i); while (!in_if.ready);
    if (cmd == CMD_ENCODE) slot_written[idx] = 1'b1;
  endtask

  task automatic maybe_pause();
    int burst;
    if (!calm && $urandom_range(0, 5) == 0) begin
      burst = $urandom_range(1, 15);
      in_if.valid <= 1'b0;
      repeat (burst) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      2, 3:    return 32'($signed($urandom_range(0, 16)) - 8) <<< 16;
      default: return 32'($signed($urandom_range(0, 2_000_000)) - 1_000_000);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 7))
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
      default: return 32'($signed($urandom_range(0, 262_144)) - 131_072);
    endcase
  endfunction

  function automatic logic [31:0] rand_label();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_8000 + $urandom_range(0, 1);
      1:       return $urandom();
      2:       return 32'h0000_0000;
      default: return 32'h0001_0000;
    endcase
  endfunction

  function automatic logic [8:0] written_slot();
    int s;
    for (int tries = 0; tries < 64; tries++) begin
      s = $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, NumSlots - 1);
      if (slot_written[s]) return s[8:0];
    end
    return 9'd0;
  endfunction

  task automatic random_item();
    logic [8:0] slot;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      push_item(CMD_LOAD_LM, $urandom_range(0, 9) == 0 ? $urandom_range(128, 511)
                : $urandom_range(0, 15) == 0 ? $urandom_range(0, NumLm - 1)
                : $urandom_range(0, 15), rand_coord(), rand_coord(), rand_label());
    end else if (pick < 35) begin
      push_item(CMD_LOAD_COEF, $urandom_range(0, 9) == 0 ? $urandom_range(12, 511)
                : $urandom_range(0, NumCoeffs - 1), rand_coef(), $urandom(), $urandom());
    end else if (pick < 70) begin
      slot = $urandom_range(0, 2) == 0 ? $urandom_range(0, NumSlots - 1)
             : $urandom_range(0, 31);
      push_item(CMD_ENCODE, slot, rand_coord(), rand_coord(), $urandom());
    end else begin
      push_item(CMD_PROJECT, written_slot(), $urandom(), $urandom(), $urandom());
    end
  endtask

  initial begin
    int waited;
    cycles = 0;
    calm = 1'b0;
    hold_go = 1'b0;
    for (int s = 0; s < NumSlots; s++) slot_written[s] = 1'b0;
    in_if.valid <= 1'b0;
    in_if.command <= CMD_LOAD_LM;
    in_if.index <= '0;
    in_if.coord_x <= '0;
    in_if.coord_y <= '0;
    in_if.label_weight <= '0;
    rst_ni <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, label threshold, ignored loads, ties, saturation.
    push_item(CMD_ENCODE, 9'd0, 32'h0001_0000, 32'hffff_0000, '0);
    push_item(CMD_PROJECT, 9'd0, '0, '0, '0);
    push_item(CMD_LOAD_LM, 9'd3, 32'h0002_0000, '0, 32'h0000_8000);
    push_item(CMD_ENCODE, 9'd1, '0, '0, '0);
    push_item(CMD_LOAD_LM, 9'd5, 32'h0002_0000, '0, 32'h0000_8001);
    push_item(CMD_LOAD_LM, 9'd9, 32'hfffe_0000, '0, 32'h7fff_ffff);
    push_item(CMD_LOAD_LM, 9'd127, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000);
    push_item(CMD_LOAD_LM, 9'd200, '0, '0, 32'h0001_0000);
    push_item(CMD_ENCODE, 9'd511, '0, '0, '0);
    push_item(CMD_ENCODE, 9'd2, 32'h7fff_ffff, 32'h8000_0000, '0);
    push_item(CMD_ENCODE, 9'd4, 32'h8000_0000, 32'h7fff_ffff, '0);
    push_item(CMD_LOAD_LM, 9'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    for (int k = 0; k < NumCoeffs; k++)
      push_item(CMD_LOAD_COEF, k[8:0], (k % 3 == 2) ? 32'h7fff_ffff : 32'h8000_0000,
                '0, '0);
    push_item(CMD_LOAD_COEF, 9'd12, 32'h0001_0000, '0, '0);
    push_item(CMD_LOAD_COEF, 9'd511, 32'h0001_0000, '0, '0);
    push_item(CMD_PROJECT, 9'd2, '0, '0, '0);
    push_item(CMD_PROJECT, 9'd511, '0, '0, '0);

    for (int n = 0; n < RandItems; n++) begin
      if (n == 300) hold_go <= 1'b1;
      if (n == RandItems - 200) calm = 1'b1;
      random_item();
      maybe_pause();
    end
    in_if.valid <= 1'b0;

    waited = 0;
    while (pending != 0) begin
      @(posedge clk_i);
      waited++;
      if (waited > 200_000) begin
        $display("Results still outstanding: %0d", pending);
        $display("Some tests failed");
        $finish;
      end
    end
    repeat (300) @(posedge clk_i);

    $display("Checked %0d encode and %0d project results over %0d cycles", encodes,
             projects, cycles);
    $display("Loads covered ignored indexes, label threshold and saturating coordinates");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
